@@ hw/rtl/ure_pkg.sv @@
// shared constants, codes and result type for the echo ranger
package ure_pkg;

    // default parameter values
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int US_PER_CM_DEF   = 58;

    // field widths
    localparam int TRIG_W   = 8;
    localparam int TOUT_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = 16;
    localparam int DIST_W   = 11;
    localparam int PHASE_W  = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_TOUT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TOUT = 2'd3;

    // configuration reset values
    localparam logic [TRIG_W-1:0] TRIG_LOW_RST  = 8'd4;
    localparam logic [TRIG_W-1:0] TRIG_HIGH_RST = 8'd10;
    localparam logic [TOUT_W-1:0] PING_TOUT_RST = 16'd6000;
    localparam logic [TOUT_W-1:0] ECHO_TOUT_RST = 16'd38000;

    // measurement phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LOW  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_WAIT = 3'd3;
    localparam logic [PHASE_W-1:0] PH_MEAS = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PREV_PING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PING_TOUT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ECHO_TOUT = 2'd3;

    typedef struct packed {
        logic                trigger_level;
        logic                busy_res;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   echo_time_us;
        logic [DIST_W-1:0]   distance_cm;
    } t_result;

endpackage

@@ hw/rtl/ure_if.sv @@
// tick and result channel interfaces
interface ure_in_if;
    logic valid;
    logic ready;
    logic command;
    logic echo_level;

    modport source (output valid, output command, output echo_level, input ready);
    modport sink   (input valid, input command, input echo_level, output ready);
endinterface

interface ure_out_if
    import ure_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                trigger_level;
    logic                busy_res;
    logic                done_res;
    logic [STATUS_W-1:0] status;
    logic [TIME_W-1:0]   echo_time_us;
    logic [DIST_W-1:0]   distance_cm;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output status, output echo_time_us, output distance_cm, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input status, input echo_time_us, input distance_cm, output ready);
endinterface

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// echo ranger top level: trigger sequencer, echo timer and result skid buffer
// an accepted tick beat's result is registered into the output or the skid register
// throughput: one tick beat per cycle while the skid register is empty; a two-entry
//   output buffer (output plus skid register) lets a tick in while a result still waits
// reset (synchronous, active low): phase idle, counters and held results zero,
//   configuration registers back to 4 / 10 / 6000 / 38000, both buffers empty
module ultrasonic_echo_ranger
    import ure_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int US_PER_CM   = US_PER_CM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ure_in_if.sink               i_in,
    ure_out_if.source            o_res
);

    localparam int CMP_W = (COUNT_WIDTH > TOUT_W) ? COUNT_WIDTH : TOUT_W;
    // remainder counter width for the running divide by US_PER_CM
    localparam int REM_W = (US_PER_CM > 1) ? $clog2(US_PER_CM) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic [REM_W-1:0]       REM_LAST = REM_W'(US_PER_CM - 1);
    // the rise tick counts as one microsecond
    localparam logic [DIST_W-1:0] Q_INIT = (US_PER_CM == 1) ? DIST_W'(1) : DIST_W'(0);
    localparam logic [REM_W-1:0]  R_INIT = (US_PER_CM == 1) ? REM_W'(0) : REM_W'(1);

    // configuration
    logic [TRIG_W-1:0] r_trig_low;
    logic [TRIG_W-1:0] r_trig_high;
    logic [TOUT_W-1:0] r_ping_tout;
    logic [TOUT_W-1:0] r_echo_tout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_low  <= TRIG_LOW_RST;
            r_trig_high <= TRIG_HIGH_RST;
            r_ping_tout <= PING_TOUT_RST;
            r_echo_tout <= ECHO_TOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TRIG_LOW:  r_trig_low  <= i_cfg_data[TRIG_W-1:0];
                CFG_TRIG_HIGH: r_trig_high <= i_cfg_data[TRIG_W-1:0];
                CFG_PING_TOUT: r_ping_tout <= i_cfg_data[TOUT_W-1:0];
                CFG_ECHO_TOUT: r_echo_tout <= i_cfg_data[TOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // timeouts above the counter top act as the top
    logic [CMP_W-1:0]       ping_ext;
    logic [CMP_W-1:0]       echo_ext;
    logic [CMP_W-1:0]       top_ext;
    logic [COUNT_WIDTH-1:0] ping_lim;
    logic [COUNT_WIDTH-1:0] echo_lim;
    logic [COUNT_WIDTH-1:0] trig_low_ext;
    logic [COUNT_WIDTH-1:0] trig_high_ext;

    always_comb begin
        ping_ext      = CMP_W'(r_ping_tout);
        echo_ext      = CMP_W'(r_echo_tout);
        top_ext       = CMP_W'(CNT_TOP);
        ping_lim      = (ping_ext > top_ext) ? CNT_TOP : ping_ext[COUNT_WIDTH-1:0];
        echo_lim      = (echo_ext > top_ext) ? CNT_TOP : echo_ext[COUNT_WIDTH-1:0];
        trig_low_ext  = COUNT_WIDTH'(r_trig_low);
        trig_high_ext = COUNT_WIDTH'(r_trig_high);
    end

    // measurement state
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [TIME_W-1:0]      r_last_time, n_last_time;
    logic [STATUS_W-1:0]    r_last_st, n_last_st;
    logic [DIST_W-1:0]      r_last_dist, n_last_dist;
    // running quotient and remainder of the echo count by US_PER_CM
    logic [DIST_W-1:0]      r_quot, n_quot;
    logic [REM_W-1:0]       r_rem, n_rem;

    logic                   push;
    logic [COUNT_WIDTH-1:0] tick_bump;
    logic                   trig;
    logic                   done;
    t_result                n_res;

    assign tick_bump = (r_tick == CNT_TOP) ? r_tick : r_tick + CNT_ONE;

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_last_time = r_last_time;
        n_last_st   = r_last_st;
        n_last_dist = r_last_dist;
        n_quot      = r_quot;
        n_rem       = r_rem;
        trig        = 1'b0;
        done        = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_in.command) begin
                    n_phase = PH_LOW;
                    n_tick  = CNT_ONE;
                end
            end
            PH_LOW: begin
                if (r_tick >= trig_low_ext) begin
                    n_phase = PH_HIGH;
                    n_tick  = CNT_ONE;
                    trig    = 1'b1;
                end else begin
                    n_tick = tick_bump;
                end
            end
            PH_HIGH: begin
                if (r_tick >= trig_high_ext) begin
                    if (i_in.echo_level) begin
                        // previous ping still ringing
                        n_phase     = PH_IDLE;
                        n_tick      = '0;
                        n_last_st   = ST_PREV_PING;
                        n_last_time = '0;
                        n_last_dist = '0;
                        done        = 1'b1;
                    end else begin
                        n_phase = PH_WAIT;
                        n_tick  = '0;
                    end
                end else begin
                    n_tick = tick_bump;
                    trig   = 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_in.echo_level) begin
                    n_phase = PH_MEAS;
                    n_tick  = CNT_ONE;
                    n_quot  = Q_INIT;
                    n_rem   = R_INIT;
                end else if (tick_bump >= ping_lim) begin
                    n_phase     = PH_IDLE;
                    n_tick      = '0;
                    n_last_st   = ST_PING_TOUT;
                    n_last_time = '0;
                    n_last_dist = '0;
                    done        = 1'b1;
                end else begin
                    n_tick = tick_bump;
                end
            end
            PH_MEAS: begin
                if (!i_in.echo_level) begin
                    n_phase     = PH_IDLE;
                    n_tick      = '0;
                    n_last_st   = ST_OK;
                    n_last_time = TIME_W'(r_tick);
                    n_last_dist = r_quot;
                    done        = 1'b1;
                end else if (r_tick >= echo_lim) begin
                    n_phase     = PH_IDLE;
                    n_tick      = '0;
                    n_last_st   = ST_ECHO_TOUT;
                    n_last_time = '0;
                    n_last_dist = '0;
                    done        = 1'b1;
                end else if (r_tick != CNT_TOP) begin
                    n_tick = r_tick + CNT_ONE;
                    // quotient follows the count, saturating at the field top
                    if (TIME_W'(n_tick) == '0) begin
                        // reported time wraps at the field width, so does its quotient
                        n_rem  = '0;
                        n_quot = '0;
                    end else if (r_rem == REM_LAST) begin
                        n_rem  = '0;
                        n_quot = (r_quot == DIST_MAX) ? r_quot : r_quot + DIST_W'(1);
                    end else begin
                        n_rem = r_rem + REM_W'(1);
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        n_res.trigger_level = trig;
        n_res.busy_res      = (n_phase != PH_IDLE);
        n_res.done_res      = done;
        n_res.status        = n_last_st;
        n_res.echo_time_us  = n_last_time;
        n_res.distance_cm   = n_last_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_last_time <= '0;
            r_last_st   <= ST_OK;
            r_last_dist <= '0;
            r_quot      <= '0;
            r_rem       <= '0;
        end else if (push) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_last_time <= n_last_time;
            r_last_st   <= n_last_st;
            r_last_dist <= n_last_dist;
            r_quot      <= n_quot;
            r_rem       <= n_rem;
        end
    end

    // result buffer: output register with a skid register behind it
    t_result r_out, r_skid;
    logic    r_out_vld, r_skid_vld;
    logic    pop;

    assign i_in.ready = !r_skid_vld;
    assign push       = i_in.valid && !r_skid_vld;
    assign pop        = r_out_vld && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.trigger_level = r_out.trigger_level;
    assign o_res.busy_res      = r_out.busy_res;
    assign o_res.done_res      = r_out.done_res;
    assign o_res.status        = r_out.status;
    assign o_res.echo_time_us  = r_out.echo_time_us;
    assign o_res.distance_cm   = r_out.distance_cm;

`ifndef SYNTHESIS
    // skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register holds a beat while output register is empty");

    // a finishing tick always returns the sequencer to idle
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && done) |=> (r_phase == PH_IDLE))
        else $error("measurement finished but phase not idle");

    // trigger only driven from the trigger phases
    a_trig_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && trig) |-> (r_phase == PH_LOW || r_phase == PH_HIGH))
        else $error("trigger driven outside trigger phases");

    // running remainder stays below the divisor while timing the echo
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MEAS) |-> (r_rem <= REM_LAST))
        else $error("echo remainder out of range");

    // a failed measurement reports zero time and distance
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && done && n_last_st != ST_OK) |-> (n_last_time == '0 && n_last_dist == '0))
        else $error("failed measurement reports a non-zero result");
`endif

endmodule

@@ tb/tb.sv @@
// self-checking bench for the echo ranger: directed tick table, then random ranging sequences
module tb
    import ure_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // run length and pacing
    localparam int N_DIR_ROWS   = 24;
    localparam int N_RESET_ROWS = 2;      // rows seen with the reset register values
    localparam int RANDOM_TICKS = 800;    // busy ticks wanted from the random part
    localparam int LAT_CYCLES   = 4;      // slack after the last result beat
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int LIMIT_NS     = 40_000_000;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE_STALL,
        RX_HEAVY_STALL
    } t_rx_mode;

    // one row of the directed table; want is used only where typed is set
    typedef struct {
        logic    cmd;
        logic    echo;
        bit      typed;
        t_result want;
    } t_tick_row;

    // typed results: idle after reset and the three failure codes
    localparam t_result R_ZERO  = '0;
    localparam t_result R_PREV  = '{1'b0, 1'b0, 1'b1, ST_PREV_PING, 16'd0, 11'd0};
    localparam t_result R_PTOUT = '{1'b0, 1'b0, 1'b1, ST_PING_TOUT, 16'd0, 11'd0};
    localparam t_result R_ETOUT = '{1'b0, 1'b0, 1'b1, ST_ECHO_TOUT, 16'd0, 11'd0};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    ure_in_if  in_if ();
    ure_out_if res_if ();

    ultrasonic_echo_ranger dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_res      (res_if)
    );

    // rows from index N_RESET_ROWS on run with low 1, high 1, ping 2, echo 3
    t_tick_row dir_rows [N_DIR_ROWS] = '{
        '{1'b0, 1'b0, 1'b1, R_ZERO},   // idle straight after reset
        '{1'b0, 1'b1, 1'b1, R_ZERO},   // echo alone does nothing in idle
        '{1'b1, 1'b0, 1'b0, R_ZERO},   // start: first trigger-low tick
        '{1'b0, 1'b0, 1'b0, R_ZERO},   // trigger goes high
        '{1'b0, 1'b1, 1'b1, R_PREV},   // echo already high when trigger drops
        '{1'b1, 1'b0, 1'b0, R_ZERO},
        '{1'b0, 1'b0, 1'b0, R_ZERO},
        '{1'b0, 1'b0, 1'b0, R_ZERO},   // into the echo wait
        '{1'b0, 1'b0, 1'b0, R_ZERO},
        '{1'b0, 1'b0, 1'b1, R_PTOUT},  // no echo before the ping timeout
        '{1'b1, 1'b0, 1'b0, R_ZERO},
        '{1'b0, 1'b1, 1'b0, R_ZERO},   // echo during trigger low is ignored
        '{1'b0, 1'b0, 1'b0, R_ZERO},
        '{1'b0, 1'b1, 1'b0, R_ZERO},   // echo rises
        '{1'b0, 1'b1, 1'b0, R_ZERO},
        '{1'b0, 1'b1, 1'b0, R_ZERO},
        '{1'b0, 1'b1, 1'b1, R_ETOUT},  // echo stays high too long
        '{1'b1, 1'b1, 1'b0, R_ZERO},
        '{1'b1, 1'b0, 1'b0, R_ZERO},   // start while busy is ignored
        '{1'b0, 1'b0, 1'b0, R_ZERO},
        '{1'b0, 1'b1, 1'b0, R_ZERO},
        '{1'b0, 1'b1, 1'b0, R_ZERO},
        '{1'b0, 1'b0, 1'b0, R_ZERO},   // good measurement of two ticks
        '{1'b0, 1'b1, 1'b0, R_ZERO}
    };

    // predictor state and its copy of the registers
    logic [PHASE_W-1:0]         p_phase;
    logic [COUNT_WIDTH_DEF-1:0] p_ticks;
    logic [TIME_W-1:0]          p_echo_time;
    logic [STATUS_W-1:0]        p_status;
    logic [TRIG_W-1:0]          c_trig_lo;
    logic [TRIG_W-1:0]          c_trig_hi;
    logic [TOUT_W-1:0]          c_ping_to;
    logic [TOUT_W-1:0]          c_echo_to;

    t_result pending_readings [$];
    int      fail_count  = 0;
    int      res_beats   = 0;
    int      busy_ticks  = 0;
    int      burst_left  = 0;
    bit      steady_send = 1'b0;
    int      hold_asked  = 0;
    int      hold_served = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // overall limit on the run
    initial begin
        #LIMIT_NS;
        $display("[ultrasonic_echo_ranger] ERROR");
        $finish;
    end

    task automatic report_fail(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    function automatic logic rbit();
        return 1'($urandom_range(0, 1));
    endfunction

    // counter that sticks at its top
    function automatic logic [COUNT_WIDTH_DEF-1:0] tick_up(input logic [COUNT_WIDTH_DEF-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // one microsecond tick of the ranger: advances the predictor and gives the result beat
    function automatic t_result ranger_predict(input logic cmd, input logic echo);
        t_result             r;
        logic                trig;
        logic                fin;
        logic [STATUS_W-1:0] fin_st;
        logic [TIME_W-1:0]   fin_time;
        logic [TIME_W-1:0]   quot;
        trig     = 1'b0;
        fin      = 1'b0;
        fin_st   = ST_OK;
        fin_time = '0;
        case (p_phase)
            PH_IDLE: begin
                if (cmd) begin
                    p_phase = PH_LOW;
                    p_ticks = COUNT_WIDTH_DEF'(1);
                end
            end
            PH_LOW: begin
                if (p_ticks >= c_trig_lo) begin
                    p_phase = PH_HIGH;
                    p_ticks = COUNT_WIDTH_DEF'(1);
                    trig    = 1'b1;
                end else begin
                    p_ticks = tick_up(p_ticks);
                end
            end
            PH_HIGH: begin
                // echo sampled on the tick the trigger drops
                if (p_ticks >= c_trig_hi) begin
                    if (echo) begin
                        fin    = 1'b1;
                        fin_st = ST_PREV_PING;
                    end else begin
                        p_phase = PH_WAIT;
                        p_ticks = '0;
                    end
                end else begin
                    p_ticks = tick_up(p_ticks);
                    trig    = 1'b1;
                end
            end
            PH_WAIT: begin
                // a rising echo wins over the timeout
                if (echo) begin
                    p_phase = PH_MEAS;
                    p_ticks = COUNT_WIDTH_DEF'(1);
                end else begin
                    p_ticks = tick_up(p_ticks);
                    if (p_ticks >= c_ping_to) begin
                        fin    = 1'b1;
                        fin_st = ST_PING_TOUT;
                    end
                end
            end
            PH_MEAS: begin
                if (!echo) begin
                    fin      = 1'b1;
                    fin_st   = ST_OK;
                    fin_time = TIME_W'(p_ticks);
                end else if (p_ticks >= c_echo_to) begin
                    fin    = 1'b1;
                    fin_st = ST_ECHO_TOUT;
                end else begin
                    p_ticks = tick_up(p_ticks);
                end
            end
            default: begin
                p_phase = PH_IDLE;
                p_ticks = '0;
            end
        endcase
        if (fin) begin
            p_status    = fin_st;
            p_echo_time = fin_time;
            p_phase     = PH_IDLE;
            p_ticks     = '0;
        end
        quot = p_echo_time / TIME_W'(US_PER_CM_DEF);
        r.trigger_level = trig;
        r.busy_res      = (p_phase != PH_IDLE);
        r.done_res      = fin;
        r.status        = p_status;
        r.echo_time_us  = p_echo_time;
        r.distance_cm   = (quot > TIME_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];
        return r;
    endfunction

    // offer one tick beat and wait for it to be taken; bursts with random gaps
    task automatic accept_tick(input logic cmd, input logic echo);
        int gap;
        if (burst_left == 0) begin
            gap = steady_send ? 0 : $urandom_range(0, 5);
            repeat (gap) begin
                in_if.valid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_if.valid      <= 1'b1;
        in_if.command    <= cmd;
        in_if.echo_level <= echo;
        @(posedge clk);
        while (in_if.ready !== 1'b1) @(posedge clk);
        burst_left--;
    endtask

    task automatic send_tick(input logic cmd, input logic echo);
        // ticks that idle ignores do not count toward the random part
        if (cmd || p_phase != PH_IDLE) busy_ticks++;
        accept_tick(cmd, echo);
        pending_readings.push_back(ranger_predict(cmd, echo));
    endtask

    // stop offering, let every result beat out, then a little slack
    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (LAT_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_TRIG_LOW:  c_trig_lo = data[TRIG_W-1:0];
            CFG_TRIG_HIGH: c_trig_hi = data[TRIG_W-1:0];
            CFG_PING_TOUT: c_ping_to = data[TOUT_W-1:0];
            CFG_ECHO_TOUT: c_echo_to = data[TOUT_W-1:0];
            default: ;
        endcase
    endtask

    // all four registers in back-to-back writes; junk in the unused upper byte of the trigger writes
    task automatic write_regs(input logic [TRIG_W-1:0] lo, input logic [TRIG_W-1:0] hi,
                              input logic [TOUT_W-1:0] pto, input logic [TOUT_W-1:0] eto);
        put_reg(CFG_TRIG_LOW,  {8'($urandom_range(0, 255)), lo});
        put_reg(CFG_TRIG_HIGH, {8'($urandom_range(0, 255)), hi});
        put_reg(CFG_PING_TOUT, pto);
        put_reg(CFG_ECHO_TOUT, eto);
        cfg_we <= 1'b0;
    endtask

    // one ranging sequence steered by the predictor's phase;
    // fixed_len of zero picks a random plan with noise and broken pings
    task automatic run_measurement(input int fixed_len);
        bit prev_ping;
        bit give_up;
        int rise_at;
        int waited;
        int len;
        int highs;
        if (fixed_len == 0) begin
            repeat ($urandom_range(0, 3)) send_tick(1'b0, rbit());
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(5, 30)) send_tick($urandom_range(0, 4) == 0, rbit());
            end
        end
        // finish whatever the noise started
        while (p_phase != PH_IDLE) send_tick(rbit(), rbit());
        prev_ping = (fixed_len == 0) && ($urandom_range(0, 6) == 0);
        send_tick(1'b1, rbit());
        // trigger pulse; echo only matters on the tick the trigger drops
        while (p_phase == PH_LOW || p_phase == PH_HIGH) begin
            send_tick(rbit(), (p_phase == PH_HIGH && p_ticks >= c_trig_hi) ? prev_ping : rbit());
        end
        give_up = (fixed_len == 0) && (c_ping_to <= 200) && ($urandom_range(0, 3) == 0);
        rise_at = (fixed_len != 0) ? 0 : $urandom_range(0, (c_ping_to < 30) ? c_ping_to : 30);
        waited  = 0;
        while (p_phase == PH_WAIT) begin
            send_tick(rbit(), !give_up && waited >= rise_at);
            waited++;
        end
        if (fixed_len != 0) len = fixed_len;
        else len = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 400 : 70);
        give_up = (fixed_len == 0) && (c_echo_to <= 300) && ($urandom_range(0, 3) == 0);
        highs   = 1;
        while (p_phase == PH_MEAS) begin
            send_tick(rbit(), give_up || highs < len);
            highs++;
        end
    endtask

    // compare one result beat with the oldest prediction
    task automatic check_reading();
        t_result got;
        t_result want;
        got.trigger_level = res_if.trigger_level;
        got.busy_res      = res_if.busy_res;
        got.done_res      = res_if.done_res;
        got.status        = res_if.status;
        got.echo_time_us  = res_if.echo_time_us;
        got.distance_cm   = res_if.distance_cm;
        res_beats++;
        if (pending_readings.size() == 0) begin
            report_fail($sformatf("result beat %0d arrived with nothing expected", res_beats));
            return;
        end
        want = pending_readings.pop_front();
        if (got.trigger_level !== want.trigger_level)
            report_fail($sformatf("beat %0d trigger_level %0d, want %0d",
                                  res_beats, got.trigger_level, want.trigger_level));
        if (got.busy_res !== want.busy_res)
            report_fail($sformatf("beat %0d busy_res %0d, want %0d",
                                  res_beats, got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
            report_fail($sformatf("beat %0d done_res %0d, want %0d",
                                  res_beats, got.done_res, want.done_res));
        if (got.status !== want.status)
            report_fail($sformatf("beat %0d status %0d, want %0d",
                                  res_beats, got.status, want.status));
        if (got.echo_time_us !== want.echo_time_us)
            report_fail($sformatf("beat %0d echo_time_us %0d, want %0d",
                                  res_beats, got.echo_time_us, want.echo_time_us));
        if (got.distance_cm !== want.distance_cm)
            report_fail($sformatf("beat %0d distance_cm %0d, want %0d",
                                  res_beats, got.distance_cm, want.distance_cm));
    endtask

    // result side: check taken beats, then pick ready from a hold-off or a stall pattern
    initial begin
        int       win_left;
        int       hold_left;
        t_rx_mode mode;
        win_left  = 0;
        hold_left = 0;
        mode      = RX_OPEN;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) check_reading();
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (hold_served != hold_asked) begin
                // long hold-off so the block fills up and pushes back on ticks
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else begin
                if (win_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    win_left = $urandom_range(8, 80);
                end
                win_left--;
                case (mode)
                    RX_OPEN:         res_if.ready <= 1'b1;
                    RX_COIN:         res_if.ready <= rbit();
                    RX_SPARSE_STALL: res_if.ready <= (win_left % 4) != 0;
                    default:         res_if.ready <= (win_left % 4) == 0;
                endcase
            end
        end
    end

    // stimulus
    initial begin
        int                ph;
        int                n_eps;
        logic [TRIG_W-1:0] lo;
        logic [TRIG_W-1:0] hi;
        logic [TOUT_W-1:0] pto;
        logic [TOUT_W-1:0] eto;
        t_result           predicted;

        in_if.valid      <= 1'b0;
        in_if.command    <= 1'b0;
        in_if.echo_level <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= CFG_TRIG_LOW;
        cfg_data         <= '0;
        rst_n            <= 1'b0;

        // predictor starts from the reset state
        p_phase     = PH_IDLE;
        p_ticks     = '0;
        p_echo_time = '0;
        p_status    = ST_OK;
        c_trig_lo   = TRIG_LOW_RST;
        c_trig_hi   = TRIG_HIGH_RST;
        c_ping_to   = PING_TOUT_RST;
        c_echo_to   = ECHO_TOUT_RST;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: typed results where obvious, predictor elsewhere
        for (int i = 0; i < N_DIR_ROWS; i++) begin
            if (i == N_RESET_ROWS) begin
                settle_block();
                write_regs(8'd1, 8'd1, 16'd2, 16'd3);
            end
            accept_tick(dir_rows[i].cmd, dir_rows[i].echo);
            predicted = ranger_predict(dir_rows[i].cmd, dir_rows[i].echo);
            pending_readings.push_back(dir_rows[i].typed ? dir_rows[i].want : predicted);
        end

        // random part: one register setting per phase, several sequences each but phase 1, which runs one
        ph = 0;
        while (busy_ticks < RANDOM_TICKS || ph < 6) begin
            settle_block();
            case (ph)
                0: begin
                    lo = TRIG_LOW_RST;  hi = TRIG_HIGH_RST;
                    pto = PING_TOUT_RST; eto = ECHO_TOUT_RST;
                end
                1: begin
                    lo = '1; hi = '1; pto = '1; eto = '1;
                end
                2: begin
                    // zero trigger times and zero timeouts
                    lo = '0; hi = '0; pto = '0; eto = '0;
                end
                3: begin
                    lo = 8'd1; hi = 8'd1; pto = 16'd1; eto = 16'd1;
                end
                default: begin
                    lo  = TRIG_W'($urandom_range(0, 6));
                    hi  = TRIG_W'($urandom_range(0, 6));
                    pto = ($urandom_range(0, 7) == 0) ? TOUT_W'($urandom_range(41, 65535))
                                                      : TOUT_W'($urandom_range(0, 40));
                    eto = ($urandom_range(0, 7) == 0) ? TOUT_W'($urandom_range(121, 65535))
                                                      : TOUT_W'($urandom_range(0, 120));
                end
            endcase
            write_regs(lo, hi, pto, eto);
            steady_send = ($urandom_range(0, 3) == 0);
            if (ph == 0 || $urandom_range(0, 4) == 0) hold_asked++;
            n_eps = (ph == 1) ? 1 : $urandom_range(2, 4);
            repeat (n_eps) run_measurement(0);
            ph++;
        end

        // drain and give any stray beat time to show up
        settle_block();
        repeat (LAT_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("[ultrasonic_echo_ranger] OK");
        end else begin
            $display("[ultrasonic_echo_ranger] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ure_pkg.sv
hw/rtl/ure_if.sv
hw/rtl/ultrasonic_echo_ranger.sv
tb/tb.sv
